/* hw/rtl/sctt_pkg.sv */
// types, constants and rounding helpers for the sine cosine tangent unit
`timescale 1ns / 1ps
package sctt_pkg;

    typedef enum logic [1:0] {
        OP_SIN = 2'd0,
        OP_COS = 2'd1,
        OP_TAN = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] angle;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overflow;
    } res_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] trig;
        logic               big;
        logic               qneg;
        logic               czero;
        logic               sneg;
    } side_t;

    localparam int DIV_STEPS = 33;
    localparam int NST = 10 + DIV_STEPS;

    localparam logic signed [63:0] TWO_PI_Q48 = 64'sh6487ED5110B46;
    localparam logic signed [63:0] PI_Q48 = 64'sh3243F6A8885A3;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DC;
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [33:0] C_SIX = 34'sd44739243;
    localparam logic signed [33:0] C_ONETWENTY = 34'sd2236962;
    localparam logic signed [33:0] C_FIVEFORTY = 34'sd53261;
    localparam logic signed [33:0] C_TWO = 34'sd134217728;
    localparam logic signed [33:0] C_TWENTYFOUR = 34'sd11184811;
    localparam logic signed [33:0] C_SEVENTWENTY = 34'sd372827;

    // shift right rounding half away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic [63:0] m;
        m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? $signed(64'd0 - m) : $signed(m);
    endfunction

    function automatic logic signed [33:0] mul28(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = round_shift(p[63:0], 28);
        return r[33:0];
    endfunction

endpackage

/* hw/rtl/sin_cos_tan_taylor_unit_core.sv */
// pipelined sine, cosine and tangent of a q8.24 angle
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_data (op, angle)
//  result  | res_valid | res_stall | res_data (value, overflow)
//
// one request per cycle while req_stall is low
// a 33 stage restoring divider follows the polynomial
// each stage holds its item unless the stage after it is empty or moving
// rst_n clears all stage valid bits, payload registers are not reset
`timescale 1ns / 1ps
module sin_cos_tan_taylor_unit_core
    import sctt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !res_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign req_stall = !en[0];
    assign res_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // range reduction
    logic [1:0]         s0_op_reg;
    logic               s0_neg_reg;
    logic signed [31:0] s0_a_reg;
    logic [61:0]        s0_prod_reg;
    logic [31:0]        in_mag;

    assign in_mag = req_data.angle[31] ? (32'd0 - $unsigned(req_data.angle))
                                       : $unsigned(req_data.angle);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_op_reg   <= req_data.op;
            s0_neg_reg  <= req_data.angle[31];
            s0_a_reg    <= req_data.angle;
            s0_prod_reg <= in_mag * INV_TWO_PI_Q32;
        end
    end

    logic [1:0]         s1_op_reg;
    logic signed [63:0] s1_r_reg;
    logic [62:0]        kfull;
    logic signed [7:0]  k_s;
    logic signed [63:0] r_next;

    always_comb
    begin
        kfull  = ({1'b0, s0_prod_reg} + (63'd1 << 55)) >> 56;
        k_s    = s0_neg_reg ? -$signed(kfull[7:0]) : $signed(kfull[7:0]);
        r_next = ({{8{s0_a_reg[31]}}, s0_a_reg, 24'd0}) - 64'(k_s * TWO_PI_Q48);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_op_reg <= s0_op_reg;
            s1_r_reg  <= r_next;
        end
    end

    logic [1:0]         s2_op_reg;
    logic signed [33:0] s2_x_reg;
    logic signed [63:0] rc;
    logic signed [63:0] xr;

    always_comb
    begin
        rc = s1_r_reg;
        if (rc > PI_Q48)
        begin
            rc = rc - TWO_PI_Q48;
        end
        if (rc < -PI_Q48)
        begin
            rc = rc + TWO_PI_Q48;
        end
        xr = round_shift(rc, 20);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_op_reg <= s1_op_reg;
            s2_x_reg  <= xr[33:0];
        end
    end

    // polynomial in horner form
    logic [1:0]         s3_op_reg, s4_op_reg, s5_op_reg, s6_op_reg, s7_op_reg;
    logic signed [33:0] s3_x_reg, s4_x_reg, s5_x_reg, s6_x_reg;
    logic signed [33:0] s3_x2_reg, s4_x2_reg, s5_x2_reg;
    logic signed [33:0] s4_ts_reg, s4_tc_reg, s5_ts_reg, s5_tc_reg;
    logic signed [33:0] s6_ts_reg, s6_c_reg, s7_s_reg, s7_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_op_reg <= s2_op_reg;
            s3_x_reg  <= s2_x_reg;
            s3_x2_reg <= mul28(s2_x_reg, s2_x_reg);
        end
        if (en[4])
        begin
            s4_op_reg <= s3_op_reg;
            s4_x_reg  <= s3_x_reg;
            s4_x2_reg <= s3_x2_reg;
            s4_ts_reg <= C_ONETWENTY - mul28(s3_x2_reg, C_FIVEFORTY);
            s4_tc_reg <= C_TWENTYFOUR - mul28(s3_x2_reg, C_SEVENTWENTY);
        end
        if (en[5])
        begin
            s5_op_reg <= s4_op_reg;
            s5_x_reg  <= s4_x_reg;
            s5_x2_reg <= s4_x2_reg;
            s5_ts_reg <= mul28(s4_x2_reg, s4_ts_reg) - C_SIX;
            s5_tc_reg <= mul28(s4_x2_reg, s4_tc_reg) - C_TWO;
        end
        if (en[6])
        begin
            s6_op_reg <= s5_op_reg;
            s6_x_reg  <= s5_x_reg;
            s6_ts_reg <= ONE_Q28 + mul28(s5_x2_reg, s5_ts_reg);
            s6_c_reg  <= ONE_Q28 + mul28(s5_x2_reg, s5_tc_reg);
        end
        if (en[7])
        begin
            s7_op_reg <= s6_op_reg;
            s7_s_reg  <= mul28(s6_x_reg, s6_ts_reg);
            s7_c_reg  <= s6_c_reg;
        end
    end

    // divider setup
    side_t              s8_side_reg;
    logic [32:0]        s8_cm_reg;
    logic [32:0]        s8_lo_reg;
    logic [32:0]        s8_rem_reg;
    logic [32:0]        sm, cm;
    logic [63:0]        num;
    logic signed [63:0] trig_full;
    side_t              side_next;

    always_comb
    begin
        sm  = s7_s_reg[33] ? (33'd0 - $unsigned(s7_s_reg[32:0])) : $unsigned(s7_s_reg[32:0]);
        cm  = s7_c_reg[33] ? (33'd0 - $unsigned(s7_c_reg[32:0])) : $unsigned(s7_c_reg[32:0]);
        num = ({31'd0, sm} << 24) + {32'd0, cm[32:1]};
        trig_full = round_shift(64'((s7_op_reg == OP_COS) ? s7_c_reg : s7_s_reg), 4);
        side_next.op    = s7_op_reg;
        side_next.trig  = trig_full[31:0];
        side_next.big   = num >= ({31'd0, cm} << 33);
        side_next.qneg  = (s7_s_reg[33] != s7_c_reg[33]) && (s7_s_reg != '0);
        side_next.czero = (s7_c_reg == '0);
        side_next.sneg  = s7_s_reg[33];
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_side_reg <= side_next;
            s8_cm_reg   <= cm;
            s8_lo_reg   <= num[32:0];
            s8_rem_reg  <= {2'd0, num[63:33]} & 33'h0FFFFFFFF;
        end
    end

    // restoring divider, one quotient bit per stage
    side_t       d_side_reg [DIV_STEPS];
    logic [32:0] d_cm_reg   [DIV_STEPS];
    logic [32:0] d_lo_reg   [DIV_STEPS];
    logic [32:0] d_rem_reg  [DIV_STEPS];
    logic [32:0] d_q_reg    [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        side_t       side_in;
        logic [32:0] cm_in, lo_in, rem_in, q_in, trial;
        logic        qbit;

        if (j == 0)
        begin : g_first
            assign side_in = s8_side_reg;
            assign cm_in   = s8_cm_reg;
            assign lo_in   = s8_lo_reg;
            assign rem_in  = s8_rem_reg;
            assign q_in    = '0;
        end
        else
        begin : g_rest
            assign side_in = d_side_reg[j-1];
            assign cm_in   = d_cm_reg[j-1];
            assign lo_in   = d_lo_reg[j-1];
            assign rem_in  = d_rem_reg[j-1];
            assign q_in    = d_q_reg[j-1];
        end

        assign trial = {rem_in[31:0], lo_in[DIV_STEPS-1-j]};
        assign qbit  = trial >= cm_in;

        always_ff @(posedge clk)
        begin
            if (en[9+j])
            begin
                d_side_reg[j] <= side_in;
                d_cm_reg[j]   <= cm_in;
                d_lo_reg[j]   <= lo_in;
                d_rem_reg[j]  <= qbit ? (trial - cm_in) : trial;
                d_q_reg[j]    <= {q_in[31:0], qbit};
            end
        end
    end

    // result select and saturation
    side_t       fs;
    logic [32:0] fq;
    res_t        res_next;
    res_t        res_reg;

    always_comb
    begin
        fs = d_side_reg[DIV_STEPS-1];
        fq = d_q_reg[DIV_STEPS-1];
        res_next.value    = '0;
        res_next.overflow = 1'b0;
        unique case (op_t'(fs.op))
            OP_SIN, OP_COS:
            begin
                res_next.value = fs.trig;
            end
            OP_TAN:
            begin
                priority if (fs.czero)
                begin
                    res_next.value    = fs.sneg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    res_next.overflow = 1'b1;
                end
                else if (!fs.qneg && (fs.big || fq > 33'h07FFFFFFF))
                begin
                    res_next.value    = 32'sh7FFFFFFF;
                    res_next.overflow = 1'b1;
                end
                else if (fs.qneg && (fs.big || fq > 33'h080000000))
                begin
                    res_next.value    = 32'sh80000000;
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    res_next.value = fs.qneg ? $signed(32'd0 - fq[31:0]) : $signed(fq[31:0]);
                end
            end
            default:
            begin
                res_next.value = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

endmodule
